### rtl/rbsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and float helpers for the ray/box slab test
// Single-precision unpack, align/add, multiply, normalize and round-to-nearest-
// even packing, plus the ordered compare used by the slab min/max logic.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	localparam int DIV_STEPS = 28;
	localparam int LANE_LAT  = DIV_STEPS + 6;
	localparam int MERGE_LAT = 3;
	localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

	localparam logic [31:0] QNAN     = 32'h7FC0_0000;
	localparam logic [31:0] POS_ZERO = 32'h0000_0000;
	localparam logic [23:0] DIV_SEED = 24'h40_0000;

	typedef struct packed {
		logic [31:0] t_entry;
		logic [31:0] t_exit;
	} slab_t;

	typedef struct packed {
		logic               special;
		logic [31:0]        sval;
		logic               sign;
		logic signed [10:0] exp;
		logic [27:0]        sum;
	} add_raw_t;

	typedef struct packed {
		logic               special;
		logic [31:0]        sval;
		logic               sign;
		logic signed [10:0] exp;
		logic [23:0]        m;
	} div_in_t;

	typedef struct packed {
		logic               special;
		logic [31:0]        sval;
		logic               sign;
		logic signed [10:0] exp;
		logic [47:0]        prod;
	} mul_raw_t;

	typedef struct packed {
		logic               special;
		logic [31:0]        sval;
		logic               sign;
		logic signed [10:0] exp;
		logic [26:0]        sig;
	} mul_norm_t;

	function automatic logic [5:0] lead_zeros(input logic [47:0] v);
		logic [5:0] cnt;
		cnt = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) cnt = 6'(47 - i);
		end
		return cnt;
	endfunction

	// sig[26] is the hidden bit at biased exponent exp; sig[2:0] guard/round/sticky
	function automatic logic [31:0] round_pack(input logic sign, input logic signed [10:0] exp,
			input logic [26:0] sig);
		logic signed [10:0] sh_full;
		logic [4:0]         sh;
		logic [26:0]        s;
		logic [26:0]        lost;
		logic [7:0]         ef;
		logic               inc;
		logic [30:0]        mag;
		logic [31:0]        res;
		sh_full = 11'sd1 - exp;
		sh      = sh_full[4:0];
		s       = sig;
		lost    = '0;
		ef      = '0;
		inc     = 1'b0;
		mag     = '0;
		if (exp >= 11'sd255) begin
			res = {sign, 8'hFF, 23'd0};
		end else begin
			if (exp < 11'sd1) begin
				if (sh_full >= 11'sd27) begin
					s = {26'd0, |sig};
				end else begin
					lost = sig << (5'd27 - sh);
					s    = sig >> sh;
					s[0] = s[0] | (|lost);
				end
				ef = 8'd0;
			end else begin
				ef = exp[7:0] - 8'd1;
			end
			inc = s[2] & (s[1] | s[0] | s[3]);
			mag = {ef, 23'd0} + {7'd0, s[26:3]} + {30'd0, inc};
			res = {sign, mag};
		end
		return res;
	endfunction

	function automatic logic is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] a);
		return a[30:0] == 31'd0;
	endfunction

	// a + b, first half: specials, swap, align, add
	function automatic add_raw_t add_pre(input logic [31:0] a, input logic [31:0] b);
		add_raw_t    r;
		logic [31:0] x;
		logic [31:0] y;
		logic [7:0]  ex;
		logic [7:0]  ey;
		logic [7:0]  d;
		logic [26:0] mx;
		logic [26:0] my;
		logic [26:0] my_al;
		logic [26:0] lost;
		r       = '0;
		x       = a;
		y       = b;
		lost    = '0;
		if (a[30:0] < b[30:0]) begin
			x = b;
			y = a;
		end
		ex    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mx    = {x[30:23] != 8'd0, x[22:0], 3'b000};
		my    = {y[30:23] != 8'd0, y[22:0], 3'b000};
		d     = ex - ey;
		my_al = my;
		if (d >= 8'd27) begin
			my_al = {26'd0, |my};
		end else begin
			lost     = my << (5'd27 - d[4:0]);
			my_al    = my >> d[4:0];
			my_al[0] = my_al[0] | (|lost);
		end
		r.sign = x[31];
		r.exp  = $signed({3'b000, ex});
		if (x[31] ^ y[31]) r.sum = {1'b0, mx} - {1'b0, my_al};
		else               r.sum = {1'b0, mx} + {1'b0, my_al};

		if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]))) begin
			r.special = 1'b1;
			r.sval    = QNAN;
		end else if (is_inf(a)) begin
			r.special = 1'b1;
			r.sval    = a;
		end else if (is_inf(b)) begin
			r.special = 1'b1;
			r.sval    = b;
		end else if (is_zero(a) && is_zero(b)) begin
			r.special = 1'b1;
			r.sval    = {a[31] & b[31], 31'd0};
		end else if (is_zero(a)) begin
			r.special = 1'b1;
			r.sval    = b;
		end else if (is_zero(b)) begin
			r.special = 1'b1;
			r.sval    = a;
		end else if (r.sum == 28'd0) begin
			r.special = 1'b1;
			r.sval    = POS_ZERO;
		end
		return r;
	endfunction

	// a + b, second half: normalize and round
	function automatic logic [31:0] add_post(input add_raw_t r);
		logic [5:0]         lz;
		logic [26:0]        sig;
		logic signed [10:0] exp;
		logic [31:0]        res;
		lz = lead_zeros({r.sum[26:0], 21'd0});
		if (r.sum[27]) begin
			sig = {r.sum[27:2], r.sum[1] | r.sum[0]};
			exp = r.exp + 11'sd1;
		end else begin
			sig = r.sum[26:0] << lz;
			exp = r.exp - $signed({5'b00000, lz});
		end
		if (r.special) res = r.sval;
		else           res = round_pack(r.sign, exp, sig);
		return res;
	endfunction

	function automatic div_in_t recip_pre(input logic [31:0] d);
		div_in_t     r;
		logic [23:0] mraw;
		logic [7:0]  eb;
		logic [5:0]  lz;
		r    = '0;
		mraw = {d[30:23] != 8'd0, d[22:0]};
		eb   = (d[30:23] == 8'd0) ? 8'd1 : d[30:23];
		lz   = lead_zeros({mraw, 24'd0});
		r.sign = d[31];
		r.m    = mraw << lz;
		r.exp  = $signed({3'b000, eb}) - $signed({5'b00000, lz});
		if (is_nan(d)) begin
			r.special = 1'b1;
			r.sval    = QNAN;
		end else if (is_inf(d)) begin
			r.special = 1'b1;
			r.sval    = {d[31], 31'd0};
		end else if (is_zero(d)) begin
			r.special = 1'b1;
			r.sval    = {d[31], 8'hFF, 23'd0};
		end
		return r;
	endfunction

	// one restoring step of 2^50 / m, quotient bit shifted in at the bottom
	function automatic logic [51:0] div_step(input logic [27:0] q, input logic [23:0] rem,
			input logic [23:0] m);
		logic [24:0] r;
		logic [27:0] qn;
		logic [23:0] rn;
		r = {rem, 1'b0};
		if (r >= {1'b0, m}) begin
			qn = {q[26:0], 1'b1};
			rn = 24'(r - {1'b0, m});
		end else begin
			qn = {q[26:0], 1'b0};
			rn = r[23:0];
		end
		return {qn, rn};
	endfunction

	function automatic logic [31:0] recip_post(input div_in_t p, input logic [27:0] q,
			input logic sticky);
		logic signed [10:0] exp;
		logic [26:0]        sig;
		logic [31:0]        res;
		if (q[27]) begin
			exp = 11'sd254 - p.exp;
			sig = q[27:1];
		end else begin
			exp = 11'sd253 - p.exp;
			sig = {q[26:1], q[0] | sticky};
		end
		if (p.special) res = p.sval;
		else           res = round_pack(p.sign, exp, sig);
		return res;
	endfunction

	function automatic mul_raw_t mul_pre(input logic [31:0] a, input logic [31:0] b);
		mul_raw_t    r;
		logic [23:0] ma;
		logic [23:0] mb;
		logic [7:0]  ea;
		logic [7:0]  eb;
		r    = '0;
		ma   = {a[30:23] != 8'd0, a[22:0]};
		mb   = {b[30:23] != 8'd0, b[22:0]};
		ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		r.sign = a[31] ^ b[31];
		r.prod = ma * mb;
		r.exp  = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
		if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
				begin
			r.special = 1'b1;
			r.sval    = QNAN;
		end else if (is_inf(a) || is_inf(b)) begin
			r.special = 1'b1;
			r.sval    = {r.sign, 8'hFF, 23'd0};
		end else if (is_zero(a) || is_zero(b)) begin
			r.special = 1'b1;
			r.sval    = {r.sign, 31'd0};
		end
		return r;
	endfunction

	function automatic mul_norm_t mul_norm(input mul_raw_t r);
		mul_norm_t   n;
		logic [5:0]  lz;
		logic [47:0] p;
		lz        = lead_zeros(r.prod);
		p         = r.prod << lz;
		n.special = r.special;
		n.sval    = r.sval;
		n.sign    = r.sign;
		n.exp     = r.exp - $signed({5'b00000, lz});
		n.sig     = {p[47:22], |p[21:0]};
		return n;
	endfunction

	function automatic logic [31:0] mul_post(input mul_norm_t n);
		logic [31:0] res;
		if (n.special) res = n.sval;
		else           res = round_pack(n.sign, n.exp, n.sig);
		return res;
	endfunction

	function automatic logic [31:0] fp_key(input logic [31:0] a);
		return a[31] ? ~a : {1'b1, a[30:0]};
	endfunction

	// IEEE a < b: false on NaN, signed zeros equal
	function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
		logic res;
		if (is_nan(a) || is_nan(b))          res = 1'b0;
		else if (is_zero(a) && is_zero(b))   res = 1'b0;
		else                                 res = fp_key(a) < fp_key(b);
		return res;
	endfunction

endpackage

### rtl/ray_box_slab_intersect_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_core: single-precision ray versus axis-aligned box
// Takes one ray/box pair per cycle while in_stall is low and returns one
// hit/distance result per pair, in order. Three axis lanes run side by
// side; the latency is set by the reciprocal in each lane, which resolves
// one quotient bit per pipeline stage (28 stages), followed by the offset
// multiply, normalize and round stages and a three-stage merge. The whole
// pipeline holds while the output is stalled, so in_stall follows
// out_stall whenever a result is waiting.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] origin_x,
	input  logic [31:0] origin_y,
	input  logic [31:0] origin_z,
	input  logic [31:0] dir_x,
	input  logic [31:0] dir_y,
	input  logic [31:0] dir_z,
	input  logic [31:0] box_lo_x,
	input  logic [31:0] box_lo_y,
	input  logic [31:0] box_lo_z,
	input  logic [31:0] box_hi_x,
	input  logic [31:0] box_hi_y,
	input  logic [31:0] box_hi_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [31:0] hit_distance
);
	import rbsi_pkg::*;

	logic [TOTAL_LAT-1:0] vld_q;
	logic                 en;
	slab_t                slab_x;
	slab_t                slab_y;
	slab_t                slab_z;

	assign en        = ~(vld_q[TOTAL_LAT-1] & out_stall);
	assign in_stall  = ~en;
	assign out_valid = vld_q[TOTAL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], in_valid};
		end
	end

	rbsi_lane u_lane_x (
		.clk    (clk),
		.en     (en),
		.origin (origin_x),
		.dir    (dir_x),
		.box_lo (box_lo_x),
		.box_hi (box_hi_x),
		.slab   (slab_x)
	);

	rbsi_lane u_lane_y (
		.clk    (clk),
		.en     (en),
		.origin (origin_y),
		.dir    (dir_y),
		.box_lo (box_lo_y),
		.box_hi (box_hi_y),
		.slab   (slab_y)
	);

	rbsi_lane u_lane_z (
		.clk    (clk),
		.en     (en),
		.origin (origin_z),
		.dir    (dir_z),
		.box_lo (box_lo_z),
		.box_hi (box_hi_z),
		.slab   (slab_z)
	);

	rbsi_merge u_merge (
		.clk          (clk),
		.en           (en),
		.slab_x       (slab_x),
		.slab_y       (slab_y),
		.slab_z       (slab_z),
		.hit          (hit),
		.hit_distance (hit_distance)
	);

endmodule

### rtl/rbsi_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_lane: one axis of the slab test
// Pipelined reciprocal (one quotient bit per stage), the two plane offsets,
// two multiplies with normalize/round stages, then entry/exit ordering.
// ----------------------------------------------------------------------------
module rbsi_lane (
	input  logic          clk,
	input  logic          en,
	input  logic [31:0]   origin,
	input  logic [31:0]   dir,
	input  logic [31:0]   box_lo,
	input  logic [31:0]   box_hi,
	output rbsi_pkg::slab_t slab
);
	import rbsi_pkg::*;

	add_raw_t    dlo_raw_s1;
	add_raw_t    dhi_raw_s1;
	div_in_t     rcp_s [0:DIV_STEPS];
	logic [23:0] rem_s [0:DIV_STEPS];
	logic [27:0] quo_s [0:DIV_STEPS];
	logic [31:0] dlo_s [1:DIV_STEPS];
	logic [31:0] dhi_s [1:DIV_STEPS];
	logic [31:0] inv_s30;
	logic [31:0] dlo_s30;
	logic [31:0] dhi_s30;
	mul_raw_t    t1_raw_s31;
	mul_raw_t    t2_raw_s31;
	mul_norm_t   t1_nrm_s32;
	mul_norm_t   t2_nrm_s32;
	logic [31:0] t1_s33;
	logic [31:0] t2_s33;
	slab_t       slab_s34;

	logic [31:0] neg_origin;

	assign neg_origin = {~origin[31], origin[30:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			rcp_s[0]   <= recip_pre(dir);
			rem_s[0]   <= DIV_SEED;
			quo_s[0]   <= '0;
			dlo_raw_s1 <= add_pre(box_lo, neg_origin);
			dhi_raw_s1 <= add_pre(box_hi, neg_origin);

			for (int k = 1; k <= DIV_STEPS; k++) begin
				rcp_s[k]             <= rcp_s[k-1];
				{quo_s[k], rem_s[k]} <= div_step(quo_s[k-1], rem_s[k-1], rcp_s[k-1].m);
			end

			dlo_s[1] <= add_post(dlo_raw_s1);
			dhi_s[1] <= add_post(dhi_raw_s1);
			for (int k = 2; k <= DIV_STEPS; k++) begin
				dlo_s[k] <= dlo_s[k-1];
				dhi_s[k] <= dhi_s[k-1];
			end

			inv_s30 <= recip_post(rcp_s[DIV_STEPS], quo_s[DIV_STEPS],
				rem_s[DIV_STEPS] != 24'd0);
			dlo_s30 <= dlo_s[DIV_STEPS];
			dhi_s30 <= dhi_s[DIV_STEPS];

			t1_raw_s31 <= mul_pre(dlo_s30, inv_s30);
			t2_raw_s31 <= mul_pre(dhi_s30, inv_s30);

			t1_nrm_s32 <= mul_norm(t1_raw_s31);
			t2_nrm_s32 <= mul_norm(t2_raw_s31);

			t1_s33 <= mul_post(t1_nrm_s32);
			t2_s33 <= mul_post(t2_nrm_s32);

			slab_s34.t_entry <= fp_lt(t1_s33, t2_s33) ? t1_s33 : t2_s33;
			slab_s34.t_exit  <= fp_lt(t2_s33, t1_s33) ? t1_s33 : t2_s33;
		end
	end

	assign slab = slab_s34;

endmodule

### rtl/rbsi_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_merge: combines the three axis slabs
// Near = latest entry, far = earliest exit, then miss test and hit distance.
// ----------------------------------------------------------------------------
module rbsi_merge (
	input  logic            clk,
	input  logic            en,
	input  rbsi_pkg::slab_t slab_x,
	input  rbsi_pkg::slab_t slab_y,
	input  rbsi_pkg::slab_t slab_z,
	output logic            hit,
	output logic [31:0]     hit_distance
);
	import rbsi_pkg::*;

	logic [31:0] near_s1;
	logic [31:0] far_s1;
	slab_t       z_s1;
	logic [31:0] near_s2;
	logic [31:0] far_s2;
	logic        hit_s3;
	logic [31:0] dist_s3;

	logic        miss;
	logic [31:0] sel_dist;

	always_comb begin
		miss     = fp_lt(far_s2, near_s2) || fp_lt(far_s2, POS_ZERO);
		sel_dist = fp_lt(near_s2, POS_ZERO) ? far_s2 : near_s2;
		if (is_nan(sel_dist)) sel_dist = QNAN;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_s1 <= fp_lt(slab_x.t_entry, slab_y.t_entry) ? slab_y.t_entry : slab_x.t_entry;
			far_s1  <= fp_lt(slab_y.t_exit, slab_x.t_exit) ? slab_y.t_exit : slab_x.t_exit;
			z_s1    <= slab_z;

			near_s2 <= fp_lt(near_s1, z_s1.t_entry) ? z_s1.t_entry : near_s1;
			far_s2  <= fp_lt(z_s1.t_exit, far_s1) ? z_s1.t_exit : far_s1;

			hit_s3  <= ~miss;
			dist_s3 <= miss ? POS_ZERO : sel_dist;
		end
	end

	assign hit          = hit_s3;
	assign hit_distance = dist_s3;

endmodule
